@@ rtl/core/wpm_pkg.sv @@
package wpm_pkg;

  // Widest pattern the block is built for
  localparam int PATTERN_MAX_DEF = 32;

  // Pattern storage: four 64-bit registers, eight bytes each
  localparam int PAT_WORDS     = 4;
  localparam int PAT_WORD_W    = 64;
  localparam int PAT_BYTES_ALL = PAT_WORDS * PAT_WORD_W / 8;
  localparam int LEN_W         = 6;

  // Wildcard characters
  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  typedef logic [7:0]            text_byte_t;
  typedef logic [2:0]            cfg_index_t;
  typedef logic [PAT_WORD_W-1:0] cfg_data_t;
  typedef logic [LEN_W-1:0]      pat_len_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LENGTH  = 3'd0,
    REG_BYTES_0 = 3'd1,
    REG_BYTES_1 = 3'd2,
    REG_BYTES_2 = 3'd3,
    REG_BYTES_3 = 3'd4
  } cfg_reg_t;

endpackage

@@ rtl/core/wpm_text_if.sv @@
interface wpm_text_if;
  import wpm_pkg::*;

  logic       valid;
  logic       ready;
  text_byte_t text_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, output text_byte, output byte_present,
                  output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input byte_present,
                  input end_of_text, output ready);
endinterface

@@ rtl/core/wpm_verdict_if.sv @@
interface wpm_verdict_if;
  import wpm_pkg::*;

  logic valid;
  logic ready;
  logic matched;
  logic text_done;

  modport source (output valid, output matched, output text_done, input ready);
  modport sink   (input valid, input matched, input text_done, output ready);
endinterface

@@ rtl/core/wpm_cfg_if.sv @@
interface wpm_cfg_if;
  import wpm_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/wildcard_pattern_matcher_core.sv @@
// Streaming wildcard matcher: each text word carries one byte (or none) and
// yields one verdict word telling whether the text so far matches the whole
// configured pattern, where '?' matches any single byte and '*' any run,
// empty included; a '*' in the pattern always acts as a wildcard. The block
// takes one text word per clock and returns its verdict in the next cycle;
// the per-prefix match column is updated by a combinational log-depth prefix
// network over the pattern positions, and the verdict register is a skid
// point, so input is stalled only while a verdict waits to be taken.
// end_of_text closes a text and the next word starts a new one; a word with
// no byte leaves the column as is, so an empty text matches only an all-star
// pattern. Configuration (length, then four 64-bit words of pattern bytes,
// lowest byte first) is accepted at any cycle and should be written while
// no text word is in flight. A length above PATTERN_MAX acts as PATTERN_MAX.
module wildcard_pattern_matcher_core #(
  parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
  input logic             clk,
  input logic             rst,
  wpm_text_if.sink        text,
  wpm_verdict_if.source   verdict,
  wpm_cfg_if.sink         cfg
);
  import wpm_pkg::*;

  localparam int CW = PATTERN_MAX + 1;
  localparam int IW = $clog2(CW);
  localparam int LV = $clog2(PATTERN_MAX);

  // Configuration registers
  pat_len_t                      pattern_length;
  logic [PAT_BYTES_ALL*8-1:0]    pattern_flat;

  // Match state
  logic [CW-1:0]                 column;
  logic [CW-1:0]                 column_next;
  logic                          at_text_start;

  // Verdict register
  logic                          result_valid;
  logic                          result_matched;
  logic                          result_done;

  logic                          text_accept;
  logic [IW-1:0]                 used_len;
  logic [PATTERN_MAX-1:0]        pos_en;
  logic [PATTERN_MAX-1:0]        pos_star;
  logic [PATTERN_MAX-1:0]        pos_hit;
  logic [CW-1:0]                 empty_col;
  logic [CW-1:0]                 base_col;
  logic [PATTERN_MAX-1:0]        ep [LV+1];
  logic [PATTERN_MAX-1:0]        gl [LV+1];
  logic [PATTERN_MAX-1:0]        pl [LV+1];

  // Write configuration registers; unknown indexes drop the write
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_flat   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LENGTH:  pattern_length <= cfg.data[LEN_W-1:0];
        REG_BYTES_0: pattern_flat[0*PAT_WORD_W +: PAT_WORD_W] <= cfg.data;
        REG_BYTES_1: pattern_flat[1*PAT_WORD_W +: PAT_WORD_W] <= cfg.data;
        REG_BYTES_2: pattern_flat[2*PAT_WORD_W +: PAT_WORD_W] <= cfg.data;
        REG_BYTES_3: pattern_flat[3*PAT_WORD_W +: PAT_WORD_W] <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clamp the length to the built column size
  assign used_len = (pattern_length > LEN_W'(PATTERN_MAX)) ? IW'(PATTERN_MAX)
                                                           : IW'(pattern_length);

  // Per-position decode of the pattern against the incoming byte
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pos_en[k]   = (IW'(k) < used_len);
      pos_star[k] = (pattern_flat[8*k +: 8] == STAR_CHAR);
      pos_hit[k]  = (pattern_flat[8*k +: 8] == text.text_byte) ||
                    (pattern_flat[8*k +: 8] == ANY_CHAR);
    end
  end

  // Empty-text column: leading run of stars, as an AND prefix
  always_comb begin
    ep[0] = pos_en & pos_star;
    for (int l = 0; l < LV; l++) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (k >= (1 << l)) begin
          ep[l+1][k] = ep[l][k] & ep[l][k - (1 << l)];
        end else begin
          ep[l+1][k] = ep[l][k];
        end
      end
    end
    empty_col = {ep[LV], 1'b1};
    base_col  = at_text_start ? empty_col : column;
  end

  // Advance the column by one byte: star runs carry upward like a carry chain
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pl[0][k] = pos_en[k] & pos_star[k];
      gl[0][k] = pos_en[k] & (pos_star[k] ? base_col[k+1]
                                          : (pos_hit[k] & base_col[k]));
    end
    for (int l = 0; l < LV; l++) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (k >= (1 << l)) begin
          gl[l+1][k] = gl[l][k] | (pl[l][k] & gl[l][k - (1 << l)]);
          pl[l+1][k] = pl[l][k] & pl[l][k - (1 << l)];
        end else begin
          gl[l+1][k] = gl[l][k];
          pl[l+1][k] = pl[l][k];
        end
      end
    end
    column_next = text.byte_present ? {gl[LV], 1'b0} : base_col;
  end

  // Accept a text word whenever the verdict register is free or draining
  assign text.ready  = !result_valid || verdict.ready;
  assign text_accept = text.valid && text.ready;

  // Hold match state between words
  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      at_text_start <= 1'b1;
    end else if (text_accept) begin
      column        <= column_next;
      at_text_start <= text.end_of_text;
    end
  end

  // Verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (text_accept) begin
      result_valid <= 1'b1;
    end else if (verdict.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_accept) begin
      result_matched <= column_next[used_len];
      result_done    <= text.end_of_text;
    end
  end

  assign verdict.valid     = result_valid;
  assign verdict.matched   = result_matched;
  assign verdict.text_done = result_done;

  // Input stalls only behind a waiting verdict
  assert property (@(posedge clk) disable iff (rst)
    !text.ready |-> (result_valid && !verdict.ready))
    else $error("text stalled without a waiting verdict");

  // A closing word restarts the next text
  assert property (@(posedge clk) disable iff (rst)
    (text_accept && text.end_of_text) |=> at_text_start)
    else $error("text start not armed after end of text");

  // Every accepted word shows a verdict next cycle with its end flag
  assert property (@(posedge clk) disable iff (rst)
    text_accept |=> (verdict.valid && verdict.text_done == $past(text.end_of_text)))
    else $error("verdict missing or end flag lost");

  // Column bits beyond the pattern length stay clear after a byte
  assert property (@(posedge clk) disable iff (rst)
    (text_accept && text.byte_present) |=>
      (((column >> $past(used_len)) >> 1) == '0))
    else $error("column bits set beyond pattern length");

endmodule
